// ----- rtl/core/csvcan_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvcan_pkg
// Shared types and constants for the CSV line to CAN command block.
// ----------------------------------------------------------------------------
package csvcan_pkg;

  localparam int unsigned LineMax   = 63;
  localparam int unsigned CountW    = $clog2(LineMax + 1);
  localparam int unsigned NumFields = 4;
  localparam int unsigned FieldIdxW = 3;
  localparam int unsigned AccW      = 32;

  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [7:0] CharComma = 8'h2C;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;

  localparam logic [AccW-1:0] AngleMax = AccW'(180);
  localparam logic [AccW-1:0] ModeMax  = AccW'(3);

  localparam int unsigned IdentW   = 11;
  localparam int unsigned LenW     = 4;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 11;

  localparam logic [CfgIdxW-1:0] CfgFrameIdent = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgFrameLen   = 1'b1;

  localparam logic [IdentW-1:0] FrameIdentRst = 11'h123;
  localparam logic [LenW-1:0]   FrameLenRst   = 4'h8;

  typedef logic [AccW-1:0] acc_t;

  typedef struct packed {
    acc_t [NumFields-1:0] acc;
    logic [CountW-1:0]    line_count;
    logic [FieldIdxW-1:0] field_index;
    logic                 stopped;
  } line_state_t;

endpackage

// ----- rtl/core/csvcan_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvcan_byte_if / csvcan_cmd_if
// Valid/ready channels for received bytes and packed commands.
// ----------------------------------------------------------------------------
interface csvcan_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface csvcan_cmd_if;
  logic        valid;
  logic        ready;
  logic [5:0]  node_id;
  logic        enable_bit;
  logic [7:0]  angle_val;
  logic [1:0]  mode_val;
  logic [17:0] payload_word;
  logic [10:0] ident_out;
  logic [3:0]  length_out;

  modport source (output valid, output node_id, output enable_bit, output angle_val,
                  output mode_val, output payload_word, output ident_out,
                  output length_out, input ready);
  modport sink   (input valid, input node_id, input enable_bit, input angle_val,
                  input mode_val, input payload_word, input ident_out,
                  input length_out, output ready);
endinterface

// ----- rtl/core/csvcan_field_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvcan_field_parser
// Per-byte line state: decimal accumulators, field index, length, stop flag.
// ----------------------------------------------------------------------------
module csvcan_field_parser (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     accept_i,
  input  logic [7:0]               rx_byte_i,
  output csvcan_pkg::line_state_t  state_o
);

  csvcan_pkg::line_state_t state_q, state_d;

  logic                              is_term;
  logic                              is_digit;
  logic [1:0]                        sel;
  csvcan_pkg::acc_t                  cur_acc;
  csvcan_pkg::acc_t                  acc_next;
  logic [csvcan_pkg::FieldIdxW-1:0]  idx_inc;

  assign is_term  = (rx_byte_i == csvcan_pkg::CharCr) || (rx_byte_i == csvcan_pkg::CharLf);
  assign is_digit = (rx_byte_i >= csvcan_pkg::CharZero) && (rx_byte_i <= csvcan_pkg::CharNine);
  assign sel      = state_q.field_index[1:0];
  assign cur_acc  = state_q.acc[sel];
  // value*10 as two shifts, wraps at the accumulator width
  assign acc_next = (cur_acc << 3) + (cur_acc << 1)
                  + csvcan_pkg::AccW'(rx_byte_i - csvcan_pkg::CharZero);
  assign idx_inc  = state_q.field_index + csvcan_pkg::FieldIdxW'(1);

  always_comb begin
    state_d = state_q;
    if (accept_i) begin
      if (is_term) begin
        state_d = '0;
      end else if (state_q.line_count < csvcan_pkg::CountW'(csvcan_pkg::LineMax)) begin
        state_d.line_count = state_q.line_count + csvcan_pkg::CountW'(1);
        if (!state_q.stopped &&
            (state_q.field_index < csvcan_pkg::FieldIdxW'(csvcan_pkg::NumFields))) begin
          if (rx_byte_i == csvcan_pkg::CharNul) begin
            state_d.stopped = 1'b1;
          end else if (is_digit) begin
            state_d.acc[sel] = acc_next;
          end else if (rx_byte_i == csvcan_pkg::CharComma) begin
            state_d.field_index = idx_inc;
            if (idx_inc >= csvcan_pkg::FieldIdxW'(csvcan_pkg::NumFields)) begin
              state_d.stopped = 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  assign state_o = state_q;

endmodule

// ----- rtl/core/csv_line_to_can_command.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csv_line_to_can_command
// Parses comma separated decimal text lines into packed CAN commands.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while byte_in.ready is high; the multiply-by-ten update is a shift-add.
// A command appears in the cycle after the accepted CR or LF that ends a non-empty line.
// Every byte waits while the result register holds a command not yet taken.
// Reset clears line state and the result valid; frame_ident resets to 0x123
// and frame_len to 8.
module csv_line_to_can_command (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  csvcan_byte_if.sink                        byte_in,
  csvcan_cmd_if.source                       cmd_out,
  input  logic                               cfg_we_i,
  input  logic [csvcan_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [csvcan_pkg::CfgDataW-1:0]    cfg_wdata_i
);

  logic [csvcan_pkg::IdentW-1:0] ident_q;
  logic [csvcan_pkg::LenW-1:0]   len_q;

  logic                    accept;
  logic                    is_term;
  logic                    emit;
  csvcan_pkg::line_state_t line_st;

  logic [5:0]       id_d;
  logic             en_d;
  csvcan_pkg::acc_t ang_clamp, mode_clamp;
  logic [7:0]       ang_d;
  logic [1:0]       mode_d;

  logic        out_valid_q;
  logic [5:0]  id_q;
  logic        en_q;
  logic [7:0]  ang_q;
  logic [1:0]  mode_q;
  logic [10:0] ident_out_q;
  logic [3:0]  len_out_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ident_q <= csvcan_pkg::FrameIdentRst;
      len_q   <= csvcan_pkg::FrameLenRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        csvcan_pkg::CfgFrameIdent: ident_q <= cfg_wdata_i[csvcan_pkg::IdentW-1:0];
        csvcan_pkg::CfgFrameLen:   len_q   <= cfg_wdata_i[csvcan_pkg::LenW-1:0];
        default: ;
      endcase
    end
  end

  assign byte_in.ready = !out_valid_q || cmd_out.ready;
  assign accept  = byte_in.valid && byte_in.ready;
  assign is_term = (byte_in.rx_byte == csvcan_pkg::CharCr) ||
                   (byte_in.rx_byte == csvcan_pkg::CharLf);
  assign emit    = accept && is_term && (line_st.line_count != '0);

  csvcan_field_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_byte_i (byte_in.rx_byte),
    .state_o   (line_st)
  );

  // signed clamp: only non-negative values above the limit are pulled down
  assign ang_clamp  = (!line_st.acc[2][csvcan_pkg::AccW-1] &&
                       (line_st.acc[2] > csvcan_pkg::AngleMax)) ?
                      csvcan_pkg::AngleMax : line_st.acc[2];
  assign mode_clamp = (!line_st.acc[3][csvcan_pkg::AccW-1] &&
                       (line_st.acc[3] > csvcan_pkg::ModeMax)) ?
                      csvcan_pkg::ModeMax : line_st.acc[3];
  assign id_d   = line_st.acc[0][5:0];
  assign en_d   = (line_st.acc[1] != '0);
  assign ang_d  = ang_clamp[7:0];
  assign mode_d = mode_clamp[1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (cmd_out.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      id_q        <= id_d;
      en_q        <= en_d;
      ang_q       <= ang_d;
      mode_q      <= mode_d;
      ident_out_q <= ident_q;
      len_out_q   <= len_q;
    end
  end

  assign cmd_out.valid        = out_valid_q;
  assign cmd_out.node_id      = id_q;
  assign cmd_out.enable_bit   = en_q;
  assign cmd_out.angle_val    = ang_q;
  assign cmd_out.mode_val     = mode_q;
  assign cmd_out.payload_word = {mode_q, ang_q, 1'b0, en_q, id_q};
  assign cmd_out.ident_out    = ident_out_q;
  assign cmd_out.length_out   = len_out_q;

  a_emit_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> out_valid_q)
    else $error("line end did not raise command valid");

  a_term_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_term) |=> (line_st.line_count == '0) && (line_st.field_index == '0))
    else $error("line state not cleared after line end");

  a_count_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_st.line_count <= csvcan_pkg::CountW'(csvcan_pkg::LineMax))
    else $error("line count above limit");

  a_index_stop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (line_st.field_index >= csvcan_pkg::FieldIdxW'(csvcan_pkg::NumFields)) |-> line_st.stopped)
    else $error("field index past last field without stop");

endmodule
